### hw/rtl/flat_bottom_distance_restraint_unit_macros.svh
// assertion helpers for the restraint unit
`ifndef FLAT_BOTTOM_DISTANCE_RESTRAINT_UNIT_MACROS_SVH
`define FLAT_BOTTOM_DISTANCE_RESTRAINT_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define FBDR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define FBDR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/fbdr_pkg.sv
package fbdr_pkg;

  // number formats
  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int BND_W       = 32;
  localparam int OUT_W       = 48;

  // datapath widths
  localparam int DW    = COORD_WIDTH + 1;   // coordinate difference
  localparam int MW    = DW;                // magnitude of difference
  localparam int D2W   = 2 * MW;            // squared distance
  localparam int RW    = D2W / 2;           // integer root
  localparam int REMW  = RW + 2;            // root remainder
  localparam int SQ_STEPS = RW;             // one root bit per stage
  localparam int ESH   = 2 * FRAC_BITS + 1; // energy scale shift
  localparam int KDW   = BND_W + RW;        // k * dev
  localparam int DSQW  = 2 * RW;            // dev * dev
  localparam int KSPL  = RW;                // split point of k * dev
  localparam int NW    = KDW + MW;          // k * dev * |delta|
  localparam int NPW   = NW - FRAC_BITS;    // scaled numerator
  localparam int DV_STEPS = OUT_W;          // one quotient bit per stage
  localparam int HIW   = NPW - DV_STEPS;    // numerator bits above quotient

  localparam logic [OUT_W-1:0] POS_CAP = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] NEG_CAP = {1'b1, {(OUT_W-1){1'b0}}};

  // violation codes
  typedef enum logic [1:0] {
    VIOL_NONE  = 2'd0,
    VIOL_CLOSE = 2'd1,
    VIOL_FAR   = 2'd2
  } viol_t;

  // payload carried through the root stages
  typedef struct packed {
    viol_t                viol;
    logic [2:0][MW-1:0]   mag;
    logic [2:0]           neg;
    logic [BND_W-1:0]     lo;
    logic [BND_W-1:0]     up;
    logic [BND_W-1:0]     k;
  } sq_pl_t;

  // payload carried through the divide stages
  typedef struct packed {
    viol_t                viol;
    logic [2:0]           neg;
    logic [OUT_W-1:0]     energy;
    logic [RW-1:0]        dm;
    logic [2:0]           ovf;
  } dv_pl_t;

endpackage

### hw/rtl/flat_bottom_distance_restraint_unit.sv
// Flat-bottom harmonic distance restraint, one atom pair per word.
// Input channel (in_valid/in_ready): two atom positions (signed Q16.16),
// lower and upper distance bounds and a force constant (unsigned Q16.16).
// Result channel (out_valid/out_ready): violation code, energy (Q32.16,
// saturating) and the gradient on the first atom (signed Q32.16, saturating);
// the second atom takes the negated gradient.
// Throughput is one word per cycle: every stage is a register stage and the
// whole pipeline advances whenever the output register is empty or being
// taken. The depth is set by the square root (one result bit per stage, 33
// stages) and the three parallel dividers (one quotient bit per stage, 48
// stages).
// When the receiver stalls, every stage holds its word and in_ready drops in
// the same cycle; nothing is lost or repeated. Reset clears all stage valid
// bits; payload registers are not reset.
`include "flat_bottom_distance_restraint_unit_macros.svh"

module flat_bottom_distance_restraint_unit
  import fbdr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [31:0]      in_ax,
  input  logic signed [31:0]      in_ay,
  input  logic signed [31:0]      in_az,
  input  logic signed [31:0]      in_bx,
  input  logic signed [31:0]      in_by,
  input  logic signed [31:0]      in_bz,
  input  logic [31:0]             in_lower_bound,
  input  logic [31:0]             in_upper_bound,
  input  logic [31:0]             in_stiffness,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              out_violation,
  output logic [47:0]             out_energy,
  output logic signed [47:0]      out_grad_x,
  output logic signed [47:0]      out_grad_y,
  output logic signed [47:0]      out_grad_z
);

  // stage positions in the valid chain
  localparam int ST_E    = 4;
  localparam int ST_SQE  = ST_E + SQ_STEPS;
  localparam int ST_F    = ST_SQE + 1;
  localparam int ST_J    = ST_F + 4;
  localparam int ST_DVE  = ST_J + DV_STEPS;
  localparam int NSTG    = ST_DVE + 2;

  logic            adv;
  logic [NSTG-1:0] vld_r;

  // global advance: output register empty or taken
  assign adv       = !vld_r[NSTG-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld_r[NSTG-1];

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  // stage a: coordinate differences
  logic [2:0][DW-1:0]  a_dlt_r;
  logic [BND_W-1:0]    a_lo_r, a_up_r, a_k_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      a_dlt_r[0] <= {in_ax[31], in_ax} - {in_bx[31], in_bx};
      a_dlt_r[1] <= {in_ay[31], in_ay} - {in_by[31], in_by};
      a_dlt_r[2] <= {in_az[31], in_az} - {in_bz[31], in_bz};
      a_lo_r     <= in_lower_bound;
      a_up_r     <= in_upper_bound;
      a_k_r      <= in_stiffness;
    end
  end

  // stage b: magnitudes and signs
  logic [2:0][MW-1:0]  b_mag_r;
  logic [2:0]          b_neg_r;
  logic [BND_W-1:0]    b_lo_r, b_up_r, b_k_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        b_neg_r[i] <= a_dlt_r[i][DW-1];
        b_mag_r[i] <= a_dlt_r[i][DW-1] ? (~a_dlt_r[i] + DW'(1)) : a_dlt_r[i];
      end
      b_lo_r <= a_lo_r;
      b_up_r <= a_up_r;
      b_k_r  <= a_k_r;
    end
  end

  // stage c: squares of differences and bounds
  logic [2:0][D2W-1:0]   c_sq_r;
  logic [2*BND_W-1:0]    c_lo2_r, c_up2_r;
  logic [2:0][MW-1:0]    c_mag_r;
  logic [2:0]            c_neg_r;
  logic [BND_W-1:0]      c_lo_r, c_up_r, c_k_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        c_sq_r[i] <= D2W'(b_mag_r[i]) * D2W'(b_mag_r[i]);
      end
      c_lo2_r <= (2*BND_W)'(b_lo_r) * (2*BND_W)'(b_lo_r);
      c_up2_r <= (2*BND_W)'(b_up_r) * (2*BND_W)'(b_up_r);
      c_mag_r <= b_mag_r;
      c_neg_r <= b_neg_r;
      c_lo_r  <= b_lo_r;
      c_up_r  <= b_up_r;
      c_k_r   <= b_k_r;
    end
  end

  // stage d: squared distance
  logic [D2W-1:0]        d_d2_r;
  logic [2*BND_W-1:0]    d_lo2_r, d_up2_r;
  logic [2:0][MW-1:0]    d_mag_r;
  logic [2:0]            d_neg_r;
  logic [BND_W-1:0]      d_lo_r, d_up_r, d_k_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      d_d2_r  <= c_sq_r[0] + c_sq_r[1] + c_sq_r[2];
      d_lo2_r <= c_lo2_r;
      d_up2_r <= c_up2_r;
      d_mag_r <= c_mag_r;
      d_neg_r <= c_neg_r;
      d_lo_r  <= c_lo_r;
      d_up_r  <= c_up_r;
      d_k_r   <= c_k_r;
    end
  end

  // stage e: classify and load the root pipeline
  logic [REMW-1:0] sq_rem_r  [SQ_STEPS+1];
  logic [RW-1:0]   sq_root_r [SQ_STEPS+1];
  logic [D2W-1:0]  sq_rad_r  [SQ_STEPS+1];
  sq_pl_t          sq_pl_r   [SQ_STEPS+1];
  viol_t           e_viol_nxt;

  always_comb begin
    priority if (d_d2_r < D2W'(d_lo2_r)) begin
      e_viol_nxt = VIOL_CLOSE;
    end else if (d_d2_r > D2W'(d_up2_r)) begin
      e_viol_nxt = VIOL_FAR;
    end else begin
      e_viol_nxt = VIOL_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_rem_r[0]     <= '0;
      sq_root_r[0]    <= '0;
      sq_rad_r[0]     <= d_d2_r;
      sq_pl_r[0].viol <= e_viol_nxt;
      sq_pl_r[0].mag  <= d_mag_r;
      sq_pl_r[0].neg  <= d_neg_r;
      sq_pl_r[0].lo   <= d_lo_r;
      sq_pl_r[0].up   <= d_up_r;
      sq_pl_r[0].k    <= d_k_r;
    end
  end

  // integer square root, one result bit per stage
  for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sq
    logic [REMW+1:0] sq_tmp;
    logic [REMW+1:0] sq_trial;
    logic            sq_ge;

    always_comb begin
      sq_tmp   = {sq_rem_r[g], sq_rad_r[g][D2W-1 -: 2]};
      sq_trial = {2'b00, sq_root_r[g], 2'b01};
      sq_ge    = (sq_tmp >= sq_trial);
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_rem_r[g+1]  <= sq_ge ? REMW'(sq_tmp - sq_trial) : REMW'(sq_tmp);
        sq_root_r[g+1] <= {sq_root_r[g][RW-2:0], sq_ge};
        sq_rad_r[g+1]  <= {sq_rad_r[g][D2W-3:0], 2'b00};
        sq_pl_r[g+1]   <= sq_pl_r[g];
      end
    end
  end

  // stage f: deviation from the violated bound
  sq_pl_t          f_pl;
  logic [RW-1:0]   f_d;
  logic [RW-1:0]   f_dev_nxt;
  logic [RW-1:0]   f_dev_r, f_dm_r;
  viol_t           f_viol_r;
  logic [2:0][MW-1:0] f_mag_r;
  logic [2:0]      f_neg_r;
  logic [BND_W-1:0] f_k_r;

  assign f_pl = sq_pl_r[SQ_STEPS];
  assign f_d  = sq_root_r[SQ_STEPS];

  always_comb begin
    unique case (f_pl.viol)
      VIOL_CLOSE: f_dev_nxt = (RW'(f_pl.lo) > f_d) ? (RW'(f_pl.lo) - f_d) : '0;
      VIOL_FAR:   f_dev_nxt = (f_d > RW'(f_pl.up)) ? (f_d - RW'(f_pl.up)) : '0;
      default:    f_dev_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_dev_r  <= f_dev_nxt;
      f_dm_r   <= (f_d == '0) ? RW'(1) : f_d;
      f_viol_r <= f_pl.viol;
      f_mag_r  <= f_pl.mag;
      f_neg_r  <= f_pl.neg;
      f_k_r    <= f_pl.k;
    end
  end

  // stage g: k * dev and dev squared
  logic [KDW-1:0]  g_kd_r;
  logic [DSQW-1:0] g_dsq_r;
  logic [RW-1:0]   g_dm_r;
  viol_t           g_viol_r;
  logic [2:0][MW-1:0] g_mag_r;
  logic [2:0]      g_neg_r;
  logic [BND_W-1:0] g_k_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      g_kd_r   <= KDW'(f_k_r) * KDW'(f_dev_r);
      g_dsq_r  <= DSQW'(f_dev_r) * DSQW'(f_dev_r);
      g_dm_r   <= f_dm_r;
      g_viol_r <= f_viol_r;
      g_mag_r  <= f_mag_r;
      g_neg_r  <= f_neg_r;
      g_k_r    <= f_k_r;
    end
  end

  // stage h: partial products, low and high halves
  localparam int ELW = BND_W + ESH;
  localparam int EHW = BND_W + DSQW - ESH;
  localparam int PLW = KSPL + MW;
  localparam int PHW = KDW - KSPL + MW;

  logic [ELW-1:0]        h_elo_r;
  logic [EHW-1:0]        h_ehi_r;
  logic [2:0][PLW-1:0]   h_plo_r;
  logic [2:0][PHW-1:0]   h_phi_r;
  logic [RW-1:0]         h_dm_r;
  viol_t                 h_viol_r;
  logic [2:0]            h_neg_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      h_elo_r <= ELW'(g_k_r) * ELW'(g_dsq_r[ESH-1:0]);
      h_ehi_r <= EHW'(g_k_r) * EHW'(g_dsq_r[DSQW-1:ESH]);
      for (int i = 0; i < 3; i++) begin
        h_plo_r[i] <= PLW'(g_kd_r[KSPL-1:0]) * PLW'(g_mag_r[i]);
        h_phi_r[i] <= PHW'(g_kd_r[KDW-1:KSPL]) * PHW'(g_mag_r[i]);
      end
      h_dm_r   <= g_dm_r;
      h_viol_r <= g_viol_r;
      h_neg_r  <= g_neg_r;
    end
  end

  // stage i: saturated energy and scaled gradient numerators
  logic [EHW:0]          i_esum;
  logic [2:0][NW-1:0]    i_nfull;
  logic [OUT_W-1:0]      i_en_r;
  logic [2:0][NPW-1:0]   i_n_r;
  logic [RW-1:0]         i_dm_r;
  viol_t                 i_viol_r;
  logic [2:0]            i_neg_r;

  always_comb begin
    i_esum = (EHW+1)'(h_ehi_r) + (EHW+1)'(h_elo_r[ELW-1:ESH]);
    for (int i = 0; i < 3; i++) begin
      i_nfull[i] = {h_phi_r[i], {KSPL{1'b0}}} + NW'(h_plo_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      i_en_r <= (|i_esum[EHW:OUT_W]) ? {OUT_W{1'b1}} : i_esum[OUT_W-1:0];
      for (int i = 0; i < 3; i++) begin
        i_n_r[i] <= i_nfull[i][NW-1:FRAC_BITS];
      end
      i_dm_r   <= h_dm_r;
      i_viol_r <= h_viol_r;
      i_neg_r  <= h_neg_r;
    end
  end

  // stage j: overflow check and load the divide pipeline
  logic [2:0][RW-1:0]    dv_rem_r [DV_STEPS+1];
  logic [2:0][OUT_W-1:0] dv_q_r   [DV_STEPS+1];
  logic [2:0][OUT_W-1:0] dv_num_r [DV_STEPS+1];
  dv_pl_t                dv_pl_r  [DV_STEPS+1];
  logic [2:0]            j_ovf_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      j_ovf_nxt[i] = (i_n_r[i][NPW-1:DV_STEPS] >= HIW'(i_dm_r));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem_r[0][i] <= i_n_r[i][DV_STEPS +: RW];
        dv_q_r[0][i]   <= '0;
        dv_num_r[0][i] <= i_n_r[i][DV_STEPS-1:0];
      end
      dv_pl_r[0].viol   <= i_viol_r;
      dv_pl_r[0].neg    <= i_neg_r;
      dv_pl_r[0].energy <= i_en_r;
      dv_pl_r[0].dm     <= i_dm_r;
      dv_pl_r[0].ovf    <= j_ovf_nxt;
    end
  end

  // restoring division by max(d, 1), one quotient bit per stage
  for (genvar g = 0; g < DV_STEPS; g++) begin : g_dv
    logic [2:0][RW:0] dv_tmp;
    logic [2:0]       dv_ge;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        dv_tmp[i] = {dv_rem_r[g][i], dv_num_r[g][i][OUT_W-1]};
        dv_ge[i]  = (dv_tmp[i] >= (RW+1)'(dv_pl_r[g].dm));
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int i = 0; i < 3; i++) begin
          dv_rem_r[g+1][i] <= dv_ge[i] ? RW'(dv_tmp[i] - (RW+1)'(dv_pl_r[g].dm))
                                       : RW'(dv_tmp[i]);
          dv_q_r[g+1][i]   <= {dv_q_r[g][i][OUT_W-2:0], dv_ge[i]};
          dv_num_r[g+1][i] <= {dv_num_r[g][i][OUT_W-2:0], 1'b0};
        end
        dv_pl_r[g+1] <= dv_pl_r[g];
      end
    end
  end

  // stage k: saturate, apply sign, output register
  dv_pl_t                k_pl;
  logic [2:0][OUT_W-1:0] k_grad_nxt;
  logic [1:0]            k_viol_r;
  logic [OUT_W-1:0]      k_en_r;
  logic [2:0][OUT_W-1:0] k_grad_r;

  assign k_pl = dv_pl_r[DV_STEPS];

  always_comb begin
    logic             pos;
    logic [OUT_W-1:0] cap;
    logic [OUT_W-1:0] qs;
    for (int i = 0; i < 3; i++) begin
      pos = (k_pl.viol == VIOL_FAR) ? !k_pl.neg[i] : k_pl.neg[i];
      cap = pos ? POS_CAP : NEG_CAP;
      qs  = (k_pl.ovf[i] || (dv_q_r[DV_STEPS][i] > cap)) ? cap : dv_q_r[DV_STEPS][i];
      k_grad_nxt[i] = pos ? qs : (~qs + OUT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k_viol_r <= k_pl.viol;
      k_en_r   <= k_pl.energy;
      k_grad_r <= k_grad_nxt;
    end
  end

  assign out_violation = k_viol_r;
  assign out_energy    = k_en_r;
  assign out_grad_x    = k_grad_r[0];
  assign out_grad_y    = k_grad_r[1];
  assign out_grad_z    = k_grad_r[2];

  // checks
  `FBDR_ASSERT_NOW(a_inside_zero, out_valid && out_violation == VIOL_NONE, out_energy == '0 && out_grad_x == '0 && out_grad_y == '0 && out_grad_z == '0, "nonzero result within bounds")
  `FBDR_ASSERT_NOW(a_root_rem, vld_r[ST_SQE], sq_rem_r[SQ_STEPS] <= REMW'({sq_root_r[SQ_STEPS], 1'b0}), "root remainder out of range")
  `FBDR_ASSERT_NOW(a_div_rem, vld_r[ST_DVE], (dv_pl_r[DV_STEPS].ovf[0] || dv_rem_r[DV_STEPS][0] < dv_pl_r[DV_STEPS].dm) && (dv_pl_r[DV_STEPS].ovf[1] || dv_rem_r[DV_STEPS][1] < dv_pl_r[DV_STEPS].dm) && (dv_pl_r[DV_STEPS].ovf[2] || dv_rem_r[DV_STEPS][2] < dv_pl_r[DV_STEPS].dm), "divide remainder not below divisor")
  `FBDR_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, $stable(vld_r), "pipeline moved during stall")

endmodule
